FILE: sv/g94v_pkg.sv
// Shared widths and types for the GOST 94 signature verification unit.
package g94v_pkg;
    localparam int P_BITS   = 64;
    localparam int Q_BITS   = 32;
    localparam int PW       = 64;   // width of p-side fields
    localparam int QW       = 32;   // width of q-side fields
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 2;
    localparam int PCNT_W   = $clog2(P_BITS + 1);
    localparam int QCNT_W   = $clog2(Q_BITS + 1);

    localparam logic [IDX_W-1:0] REG_P = 2'd0;
    localparam logic [IDX_W-1:0] REG_Q = 2'd1;
    localparam logic [IDX_W-1:0] REG_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_Y = 2'd3;

    typedef struct packed {
        logic [PW-1:0] msg_hash;
        logic [QW-1:0] sig_r;
        logic [QW-1:0] sig_s;
    } in_word_t;

    typedef struct packed {
        logic [QW-1:0] u1;
        logic [QW-1:0] u2;
        logic [QW-1:0] check_value;
        logic          valid_res;
        logic          error;
    } out_word_t;
endpackage

FILE: sv/g94v_if.sv
// Valid/ready channel interface carrying one word.
interface g94v_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/gost94_signature_verify_unit.sv
// Top level of the GOST 94 signature verification unit.
//
//  channel   dir  word         accepted when
//  in_ch     in   in_word_t    in_ch.valid && in_ch.ready
//  out_ch    out  out_word_t   out_ch.valid && out_ch.ready
//  cfg       in   index, data  cfg_we
//
// One item at a time. Multiplies and reductions run bit serially on one modular
// double/add step and one restoring remainder step, one operand bit per cycle.
// The time to a result grows with the number of Euclid steps (at most 46 for a
// 32-bit q); errors leave early.
// Input is refused while a result waits; reset drops any waiting result.
module gost94_signature_verify_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [g94v_pkg::IDX_W-1:0] cfg_index,
    input  logic [g94v_pkg::CFG_W-1:0] cfg_data,
    g94v_if.sink                       in_ch,
    g94v_if.source                     out_ch
);
    import g94v_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_HRED, S_QCHK, S_EUC_DIV, S_EUC_MUL, S_EUC_NEXT,
        S_U1, S_U2NEG, S_U2, S_AR, S_YR, S_EXP_SQ, S_EXP_MA, S_EXP_MY,
        S_VMUL, S_VRED, S_DONE
    } state_t;

    // ------------------------------------------------------------------
    logic [PW-1:0] p_reg, a_reg, y_reg;
    logic [QW-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
            q_reg <= '0;
            a_reg <= '0;
            y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P:   p_reg <= cfg_data;
                REG_Q:   q_reg <= cfg_data[QW-1:0];
                REG_A:   a_reg <= cfg_data;
                REG_Y:   y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [PW-1:0] pm, qm;
    assign pm = p_reg & (PW'({PW{1'b1}}) >> (PW - P_BITS));
    assign qm = PW'(q_reg) & (PW'({PW{1'b1}}) >> (PW - Q_BITS));

    // ------------------------------------------------------------------
    state_t          state_reg;
    logic [PW-1:0]   hh_reg, rr_reg, ss_reg;
    // shared serial unit: acc = (acc*2 [+ x]) mod m, or restoring remainder
    logic [PW-1:0]   acc_reg, x_reg, m_reg;
    logic [PW-1:0]   sh_reg;               // multiplier / dividend bits
    logic [6:0]      cnt_reg;              // bit counter, counts down
    logic [PW-1:0]   r0_reg, r1_reg, t0_reg, t1_reg, qt_reg;
    logic [PW-1:0]   w_reg, u1_reg, u2_reg, e1_reg, e2_reg;
    logic [PW-1:0]   ab_reg, yb_reg, res_reg;
    logic [6:0]      ecnt_reg;
    logic            out_valid_reg;
    out_word_t       out_reg;

    // one step of modular double-and-add
    logic [PW:0]   dbl, add2;
    logic [PW-1:0] dred, step_mul;
    always_comb
    begin
        dbl  = {acc_reg, 1'b0};
        dred = (dbl >= {1'b0, m_reg}) ? PW'(dbl - {1'b0, m_reg}) : dbl[PW-1:0];
        add2 = {1'b0, dred} + {1'b0, x_reg};
        step_mul = sh_reg[PW-1]
                 ? ((add2 >= {1'b0, m_reg}) ? PW'(add2 - {1'b0, m_reg}) : add2[PW-1:0])
                 : dred;
    end

    // one step of restoring division: remainder in acc, quotient into sh low end
    logic [PW:0]   rem_sh;
    logic          rem_ge;
    logic [PW-1:0] rem_next;
    assign rem_sh   = {acc_reg, sh_reg[PW-1]};
    assign rem_ge   = rem_sh >= {1'b0, m_reg};
    assign rem_next = rem_ge ? PW'(rem_sh - {1'b0, m_reg}) : rem_sh[PW-1:0];

    logic [PW:0] subm;
    assign subm = {1'b0, t0_reg} + {1'b0, qm} - {1'b0, acc_reg};

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        hh_reg  <= in_ch.data.msg_hash;
                        rr_reg  <= PW'(in_ch.data.sig_r);
                        ss_reg  <= PW'(in_ch.data.sig_s);
                        state_reg <= S_QCHK;
                    end
                end
                S_QCHK:
                begin
                    if (pm == '0 || qm <= PW'(1))
                    begin
                        out_reg       <= '{default: '0, error: 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        // h mod q by serial division
                        acc_reg   <= '0;
                        sh_reg    <= hh_reg;
                        m_reg     <= qm;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_HRED;
                    end
                end
                S_HRED:
                begin
                    acc_reg <= rem_next;
                    sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        r0_reg    <= qm;
                        r1_reg    <= rem_next;
                        t0_reg    <= '0;
                        t1_reg    <= PW'(1);
                        state_reg <= S_EUC_NEXT;
                    end
                end
                S_EUC_NEXT:
                begin
                    if (r1_reg == '0)
                    begin
                        if (r0_reg != PW'(1))
                        begin
                            out_reg       <= '{default: '0, error: 1'b1};
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            w_reg     <= t0_reg;
                            // u1 = (s mod q) * w; s < 2^32 so reduce first
                            acc_reg   <= '0;
                            sh_reg    <= ss_reg;
                            m_reg     <= qm;
                            cnt_reg   <= 7'(PW);
                            state_reg <= S_U1;
                        end
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        sh_reg    <= r0_reg;
                        m_reg     <= r1_reg;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_EUC_DIV;
                    end
                end
                S_EUC_DIV:
                begin
                    acc_reg <= rem_next;
                    sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        r0_reg <= r1_reg;
                        r1_reg <= rem_next;
                        qt_reg <= {sh_reg[PW-2:0], rem_ge};
                        state_reg <= S_EUC_MUL;
                    end
                end
                S_EUC_MUL:
                begin
                    // qt may reach q, the serial product still gives qt*t1 mod q
                    if (cnt_reg == 7'd0)
                    begin
                        acc_reg <= '0;
                        x_reg   <= t1_reg;
                        sh_reg  <= qt_reg;
                        m_reg   <= qm;
                        cnt_reg <= 7'(PW + 1);
                    end
                    else
                    begin
                        acc_reg <= step_mul;
                        sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 7'd1;
                        if (cnt_reg == 7'd1)
                        begin
                            // t2 = t0 - qt*t1 mod q
                            t0_reg <= t1_reg;
                            t1_reg <= (t0_reg >= acc_reg) ? t0_reg - acc_reg : subm[PW-1:0];
                            state_reg <= S_EUC_NEXT;
                        end
                    end
                end
                S_U1:
                begin
                    // first reduce s mod q, then multiply
                    if (cnt_reg == 7'd1)
                    begin
                        x_reg     <= rem_next;
                        acc_reg   <= '0;
                        sh_reg    <= w_reg;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_U2NEG;
                        ecnt_reg  <= 7'd0;
                    end
                    else
                    begin
                        acc_reg <= rem_next;
                        sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_U2NEG:
                begin
                    // u1 product, then reduce r, then u2 product
                    if (cnt_reg == 7'd1)
                    begin
                        u1_reg    <= step_mul;
                        acc_reg   <= '0;
                        sh_reg    <= rr_reg;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_U2;
                    end
                    else
                    begin
                        acc_reg <= step_mul;
                        sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_U2:
                begin
                    if (ecnt_reg == 7'd0)
                    begin
                        if (cnt_reg == 7'd1)
                        begin
                            x_reg    <= (rem_next == '0) ? '0 : qm - rem_next;
                            acc_reg  <= '0;
                            sh_reg   <= w_reg;
                            cnt_reg  <= 7'(PW);
                            ecnt_reg <= 7'd1;
                        end
                        else
                        begin
                            acc_reg <= rem_next;
                            sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == 7'd1)
                        begin
                            u2_reg    <= step_mul;
                            e2_reg    <= step_mul;
                            e1_reg    <= u1_reg;
                            acc_reg   <= '0;
                            sh_reg    <= a_reg;
                            m_reg     <= pm;
                            cnt_reg   <= 7'(PW);
                            state_reg <= S_AR;
                        end
                        else
                        begin
                            acc_reg <= step_mul;
                            sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                end
                S_AR:
                begin
                    if (cnt_reg == 7'd1)
                    begin
                        ab_reg    <= rem_next;
                        acc_reg   <= '0;
                        sh_reg    <= y_reg;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_YR;
                    end
                    else
                    begin
                        acc_reg <= rem_next;
                        sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_YR:
                begin
                    if (cnt_reg == 7'd1)
                    begin
                        yb_reg    <= rem_next;
                        // res = 1 mod p, then square-and-multiply over exponent bits
                        res_reg   <= (pm == PW'(1)) ? '0 : PW'(1);
                        ecnt_reg  <= 7'(QW);
                        e1_reg    <= e1_reg << (PW - QW);
                        e2_reg    <= e2_reg << (PW - QW);
                        acc_reg   <= '0;
                        x_reg     <= (pm == PW'(1)) ? '0 : PW'(1);
                        sh_reg    <= (pm == PW'(1)) ? '0 : PW'(1);
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_EXP_SQ;
                    end
                    else
                    begin
                        acc_reg <= rem_next;
                        sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_EXP_SQ:
                begin
                    if (cnt_reg == 7'd1)
                    begin
                        res_reg   <= step_mul;
                        acc_reg   <= '0;
                        x_reg     <= ab_reg;
                        sh_reg    <= e1_reg[PW-1] ? step_mul : '0;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_EXP_MA;
                    end
                    else
                    begin
                        acc_reg <= step_mul;
                        sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_EXP_MA:
                begin
                    if (cnt_reg == 7'd1)
                    begin
                        if (e1_reg[PW-1])
                            res_reg <= step_mul;
                        acc_reg   <= '0;
                        x_reg     <= yb_reg;
                        sh_reg    <= e2_reg[PW-1] ? (e1_reg[PW-1] ? step_mul : res_reg) : '0;
                        cnt_reg   <= 7'(PW);
                        state_reg <= S_EXP_MY;
                    end
                    else
                    begin
                        acc_reg <= step_mul;
                        sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_EXP_MY:
                begin
                    if (cnt_reg == 7'd1)
                    begin
                        e1_reg   <= e1_reg << 1;
                        e2_reg   <= e2_reg << 1;
                        ecnt_reg <= ecnt_reg - 7'd1;
                        acc_reg  <= '0;
                        cnt_reg  <= 7'(PW);
                        if (e2_reg[PW-1])
                        begin
                            res_reg <= step_mul;
                            x_reg   <= step_mul;
                            sh_reg  <= step_mul;
                        end
                        else
                        begin
                            x_reg  <= res_reg;
                            sh_reg <= res_reg;
                        end
                        // after the last bit, reduce the product mod q
                        if (ecnt_reg == 7'd1)
                        begin
                            m_reg     <= qm;
                            state_reg <= S_VRED;
                        end
                        else
                            state_reg <= S_EXP_SQ;
                    end
                    else
                    begin
                        acc_reg <= step_mul;
                        sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_VMUL:
                    state_reg <= S_VRED;
                S_VRED:
                begin
                    acc_reg <= rem_next;
                    sh_reg  <= {sh_reg[PW-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        out_reg.u1          <= u1_reg[QW-1:0];
                        out_reg.u2          <= u2_reg[QW-1:0];
                        out_reg.check_value <= rem_next[QW-1:0];
                        out_reg.valid_res   <= rem_next == rr_reg;
                        out_reg.error       <= 1'b0;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while busy");
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.error) |-> (out_ch.data.u1 == '0 && !out_ch.data.valid_res))
        else $error("error result carries data");
    a_idle_no_ready_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ch.ready)
        else $error("ready while result waits");
`endif
endmodule
